>>> design/ist_pkg.sv
// ----------------------------------------------------------------------------
// Interval set table package
// Shared types and constants for the interval set table.
// ----------------------------------------------------------------------------
`default_nettype none
package ist_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned CoordBits  = 30;
  localparam int unsigned IdxBits    = $clog2(TableDepth);
  localparam int unsigned CntBits    = $clog2(TableDepth + 1);

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [IdxBits-1:0]   idx_t;
  typedef logic [CntBits-1:0]   cnt_t;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DECIDE,
    FSM_MOVE,
    FSM_WRITE,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [29:0] range_start;
    logic [30:0] range_stop;
  } req_t;

  typedef struct packed {
    logic       covered;
    logic [1:0] status;
    logic [6:0] interval_count;
  } rsp_t;

  // One table entry: a closed interval.
  typedef struct packed {
    coord_t lo;
    coord_t hi;
  } entry_t;

  // Memory access port from the controller.
  typedef struct packed {
    logic   rd_en;
    idx_t   rd_addr;
    logic   wr_en;
    idx_t   wr_addr;
    entry_t wr_data;
  } mem_req_t;

endpackage
`default_nettype wire

>>> design/ist_ram.sv
// ----------------------------------------------------------------------------
// Interval set table memory
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module ist_ram (
  input  wire logic             clk_i,
  input  wire ist_pkg::mem_req_t req_i,
  output ist_pkg::entry_t        rd_data_o
);

  ist_pkg::entry_t mem_q [ist_pkg::TableDepth];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_o <= mem_q[req_i.rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> design/ist_ctrl.sv
// ----------------------------------------------------------------------------
// Interval set table controller
// Scans the sorted table; for an add or remove, then shifts the tail and writes the new pieces.
// ----------------------------------------------------------------------------
`default_nettype none
module ist_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire ist_pkg::req_t     req_i,
  output logic                   busy_o,
  output logic                   done_o,
  output ist_pkg::rsp_t          rsp_o,
  output ist_pkg::mem_req_t      mem_o,
  input  wire ist_pkg::entry_t   mem_rd_i
);

  localparam int unsigned CB = ist_pkg::CntBits;
  localparam int unsigned XB = ist_pkg::CoordBits + 1;

  ist_pkg::fsm_e state_q, state_d;
  ist_pkg::cmd_e cmd_q, cmd_d;
  logic [XB-1:0] a_q, a_d, b_q, b_d;
  ist_pkg::cnt_t cnt_q, cnt_d;
  ist_pkg::cnt_t scan_q, scan_d;
  ist_pkg::cnt_t i_q, i_d, j_q, j_d;
  logic          found_i_q, found_i_d;
  logic          rd_v_q, rd_v_d;
  ist_pkg::entry_t first_q, first_d, last_q, last_d;
  ist_pkg::entry_t p0_q, p0_d, p1_q, p1_d;
  ist_pkg::cnt_t np_q, np_d;
  ist_pkg::cnt_t mv_q, mv_d;
  ist_pkg::cnt_t wk_q, wk_d;
  logic          covered_q, covered_d;
  logic [1:0]    status_q, status_d;

  logic [XB-1:0] rlo, rhi, stop_sat;
  ist_pkg::cnt_t rd_idx, cut, new_cnt;
  logic          shift_up;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ist_pkg::FSM_IDLE;
      cnt_q   <= '0;
      rd_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rd_v_q  <= rd_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; a_q <= a_d; b_q <= b_d; scan_q <= scan_d;
    i_q <= i_d; j_q <= j_d; found_i_q <= found_i_d;
    first_q <= first_d; last_q <= last_d; p0_q <= p0_d; p1_q <= p1_d;
    np_q <= np_d; mv_q <= mv_d; wk_q <= wk_d;
    covered_q <= covered_d; status_q <= status_d;
  end

  assign rlo      = {1'b0, mem_rd_i.lo};
  assign rhi      = {1'b0, mem_rd_i.hi};
  assign rd_idx   = scan_q - CB'(1);
  assign cut      = j_q - i_q;
  assign new_cnt  = cnt_q - cut + np_q;
  assign shift_up = (np_q > cut);
  assign stop_sat = req_i.range_stop > {1'b1, {(XB-1){1'b0}}} ?
                    {1'b1, {(XB-1){1'b0}}} : req_i.range_stop;

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; a_d = a_q; b_d = b_q; cnt_d = cnt_q;
    scan_d = scan_q; i_d = i_q; j_d = j_q; found_i_d = found_i_q;
    rd_v_d = 1'b0; first_d = first_q; last_d = last_q;
    p0_d = p0_q; p1_d = p1_q; np_d = np_q; mv_d = mv_q; wk_d = wk_q;
    covered_d = covered_q; status_d = status_q;
    mem_o = '0;
    busy_o = (state_q != ist_pkg::FSM_IDLE);
    done_o = 1'b0;
    rsp_o.covered = covered_q;
    rsp_o.status = status_q;
    rsp_o.interval_count = 7'(cnt_q);

    unique case (state_q)
      ist_pkg::FSM_IDLE: begin
        if (start_i) begin
          cmd_d = ist_pkg::cmd_e'(req_i.command);
          covered_d = 1'b0;
          status_d = ist_pkg::ST_OK;
          a_d = {1'b0, req_i.range_start};
          b_d = stop_sat - XB'(1);
          scan_d = '0; i_d = cnt_q; j_d = cnt_q; found_i_d = 1'b0;
          np_d = '0;
          if (req_i.command == ist_pkg::CMD_NONE) begin
            state_d = ist_pkg::FSM_DONE;
          end else if (stop_sat <= {1'b0, req_i.range_start}) begin
            status_d = ist_pkg::ST_EMPTY;
            state_d = ist_pkg::FSM_DONE;
          end else begin
            state_d = ist_pkg::FSM_SCAN;
          end
        end
      end
      ist_pkg::FSM_SCAN: begin
        // Issue one read per cycle; examine the previous read's data.
        if (scan_q < cnt_q) begin
          mem_o.rd_en = 1'b1;
          mem_o.rd_addr = ist_pkg::idx_t'(scan_q);
          rd_v_d = 1'b1;
        end
        scan_d = scan_q + CB'(1);
        if (rd_v_q) begin
          unique case (cmd_q)
            ist_pkg::CMD_ADD: begin
              if (!found_i_q) begin
                if (!(rhi + XB'(1) < a_q)) begin
                  found_i_d = 1'b1; i_d = rd_idx; first_d = mem_rd_i;
                  if (rlo <= b_q + XB'(1)) begin
                    last_d = mem_rd_i; j_d = scan_q;
                  end else begin
                    j_d = rd_idx; state_d = ist_pkg::FSM_DECIDE;
                  end
                end
              end else if (rlo <= b_q + XB'(1)) begin
                last_d = mem_rd_i; j_d = scan_q;
              end else begin
                state_d = ist_pkg::FSM_DECIDE;
              end
            end
            ist_pkg::CMD_REMOVE: begin
              if (!found_i_q) begin
                if (!(rhi < a_q)) begin
                  found_i_d = 1'b1; i_d = rd_idx; first_d = mem_rd_i;
                  if (rlo <= b_q) begin
                    last_d = mem_rd_i; j_d = scan_q;
                  end else begin
                    j_d = rd_idx; state_d = ist_pkg::FSM_DECIDE;
                  end
                end
              end else if (rlo <= b_q) begin
                last_d = mem_rd_i; j_d = scan_q;
              end else begin
                state_d = ist_pkg::FSM_DECIDE;
              end
            end
            default: begin
              if (rlo <= a_q && a_q <= rhi) begin
                covered_d = (rhi >= b_q);
                state_d = ist_pkg::FSM_DONE;
              end
            end
          endcase
        end
        if (!rd_v_q && scan_q != '0 && state_d == ist_pkg::FSM_SCAN) begin
          state_d = (cmd_q == ist_pkg::CMD_QUERY) ? ist_pkg::FSM_DONE
                                                  : ist_pkg::FSM_DECIDE;
        end
        if (scan_q >= cnt_q && !rd_v_q) begin
          state_d = (cmd_q == ist_pkg::CMD_QUERY) ? ist_pkg::FSM_DONE
                                                  : ist_pkg::FSM_DECIDE;
        end
        if (state_d != ist_pkg::FSM_SCAN) begin
          rd_v_d = 1'b0;
        end
      end
      ist_pkg::FSM_DECIDE: begin
        found_i_d = 1'b0;
        if (cmd_q == ist_pkg::CMD_ADD) begin
          p0_d.lo = (j_q > i_q && {1'b0, first_q.lo} < a_q) ? first_q.lo
                                                            : a_q[XB-2:0];
          p0_d.hi = (j_q > i_q && {1'b0, last_q.hi} > b_q) ? last_q.hi
                                                           : b_q[XB-2:0];
          np_d = CB'(1);
        end else begin
          np_d = '0;
          if (j_q > i_q && {1'b0, first_q.lo} < a_q) begin
            p0_d.lo = first_q.lo; p0_d.hi = a_q[XB-2:0] - ist_pkg::coord_t'(1);
            np_d = CB'(1);
            if ({1'b0, last_q.hi} > b_q) begin
              p1_d.lo = b_q[XB-2:0] + ist_pkg::coord_t'(1); p1_d.hi = last_q.hi;
              np_d = CB'(2);
            end
          end else if (j_q > i_q && {1'b0, last_q.hi} > b_q) begin
            p0_d.lo = b_q[XB-2:0] + ist_pkg::coord_t'(1); p0_d.hi = last_q.hi;
            np_d = CB'(1);
          end
        end
        state_d = ist_pkg::FSM_MOVE;
      end
      ist_pkg::FSM_MOVE: begin
        // Check capacity, then move the tail one entry at a time, reading it and then writing it at its new place.
        if ({1'b0, cnt_q} - {1'b0, cut} + {1'b0, np_q} >
            (CB+1)'(ist_pkg::TableDepth)) begin
          status_d = ist_pkg::ST_FULL;
          state_d = ist_pkg::FSM_DONE;
        end else if (np_q == cut || j_q == cnt_q) begin
          wk_d = '0;
          state_d = ist_pkg::FSM_WRITE;
        end else begin
          mv_d = shift_up ? cnt_q - CB'(1) : j_q;
          wk_d = '0;
          rd_v_d = 1'b0;
          state_d = ist_pkg::FSM_WRITE;
          np_d = np_q;
          scan_d = shift_up ? cnt_q : j_q;
          state_d = ist_pkg::FSM_MOVE;
          found_i_d = 1'b0;
          if (!found_i_q) begin
            found_i_d = 1'b1;
            mv_d = shift_up ? cnt_q - CB'(1) : j_q;
          end else begin
            mv_d = mv_q;
          end
          if (found_i_q) begin
            if (!rd_v_q) begin
              mem_o.rd_en = 1'b1;
              mem_o.rd_addr = ist_pkg::idx_t'(mv_q);
              rd_v_d = 1'b1;
              found_i_d = 1'b1;
            end else begin
              mem_o.wr_en = 1'b1;
              mem_o.wr_addr = ist_pkg::idx_t'(mv_q - cut + np_q);
              mem_o.wr_data = mem_rd_i;
              found_i_d = 1'b1;
              if (shift_up) begin
                if (mv_q == j_q) begin
                  state_d = ist_pkg::FSM_WRITE;
                end else begin
                  mv_d = mv_q - CB'(1);
                end
              end else begin
                if (mv_q == cnt_q - CB'(1)) begin
                  state_d = ist_pkg::FSM_WRITE;
                end else begin
                  mv_d = mv_q + CB'(1);
                end
              end
            end
          end
        end
      end
      ist_pkg::FSM_WRITE: begin
        if (wk_q < np_q) begin
          mem_o.wr_en = 1'b1;
          mem_o.wr_addr = ist_pkg::idx_t'(i_q + wk_q);
          mem_o.wr_data = (wk_q == '0) ? p0_q : p1_q;
          wk_d = wk_q + CB'(1);
        end else begin
          cnt_d = new_cnt;
          state_d = ist_pkg::FSM_DONE;
        end
      end
      ist_pkg::FSM_DONE: begin
        done_o = 1'b1;
        state_d = ist_pkg::FSM_IDLE;
      end
      default: state_d = ist_pkg::FSM_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> design/interval_set_table_core.sv
// ----------------------------------------------------------------------------
// Interval set table core
// Sorted table of disjoint closed intervals with add, remove and query.
// ----------------------------------------------------------------------------
// Usage: drive req_i and raise start; the command is taken at a clock edge
// where start is high and busy is low. busy stays high until the result
// transfer, which is shown on rsp_o for one cycle with done_o high. The
// receiver cannot stall, so the result is simply taken in that cycle.
// Operation: the scan reads one table entry per cycle through the single read
// port of the table memory. An add or remove then decides the new pieces,
// sets up the move, reads and then writes each tail entry that moves when
// the number of entries changes, writes each new piece, updates the count
// and shows the result. The slowest command shifts 63 entries; an empty
// range or the unused command shows its result in the next cycle.
// A new command can be taken in the cycle after the result. One command is in
// flight at a time. Reset clears the interval count; the table contents need
// no clearing, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none
module interval_set_table_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire ist_pkg::req_t req_i,
  output logic               busy,
  output logic               done_o,
  output ist_pkg::rsp_t      rsp_o
);

  ist_pkg::mem_req_t mem_req;
  ist_pkg::entry_t   mem_rd;

  ist_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .req_i    (req_i),
    .busy_o   (busy),
    .done_o   (done_o),
    .rsp_o    (rsp_o),
    .mem_o    (mem_req),
    .mem_rd_i (mem_rd)
  );

  ist_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (mem_rd)
  );

endmodule
`default_nettype wire

>>> design/ist_checker.sv
// ----------------------------------------------------------------------------
// Interval set table checker
// Port-level assertions on the command handshake and results.
// ----------------------------------------------------------------------------
`default_nettype none
module ist_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done_o,
  input wire ist_pkg::rsp_t rsp_o
);

  // An accepted command makes the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted command did not set busy");

  // A result is shown only while busy and busy drops right after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy ##1 !busy) else $error("result outside a command");

  // The count shown with a result never exceeds the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.interval_count <= 7'd64) else $error("count overflow");

  // Coverage is only reported with an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.covered |-> rsp_o.status == ist_pkg::ST_OK)
    else $error("covered with bad status");

endmodule

bind interval_set_table_core ist_checker u_ist_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
`default_nettype wire

>>> tb/tb_interval_set_table_core.sv
// ----------------------------------------------------------------------------
// Interval set table core testbench
// Sends add, remove, query and unused commands through the start/busy handshake and
// checks every result against a behavioral table of intervals kept here.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_interval_set_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned SpaceEnd = 64'd1 << ist_pkg::CoordBits;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start = 1'b0;
  ist_pkg::req_t  req_i = '0;
  logic           busy;
  logic           done_o;
  ist_pkg::rsp_t  rsp_o;

  interval_set_table_core uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .req_i (req_i),
    .busy  (busy),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  always #10 clk_i = ~clk_i;

  longint unsigned span_lo[$];
  longint unsigned span_hi[$];
  ist_pkg::rsp_t   pending_rsp[$];
  int              mismatches = 0;
  int              send_gap_pct = 0;

  function automatic ist_pkg::rsp_t apply_command(ist_pkg::req_t r);
    ist_pkg::rsp_t   res;
    longint unsigned a, b, s, e, nlo, nhi;
    int              c, i, j, np;
    longint unsigned plo[2], phi[2];
    res = '0;
    c = span_lo.size();
    s = r.range_start;
    e = r.range_stop;
    if (e > SpaceEnd) e = SpaceEnd;
    if (ist_pkg::cmd_e'(r.command) == ist_pkg::CMD_NONE) begin
    end else if (e <= s) begin
      res.status = ist_pkg::ST_EMPTY;
    end else begin
      a = s;
      b = e - 1;
      if (ist_pkg::cmd_e'(r.command) == ist_pkg::CMD_ADD) begin
        i = 0;
        while (i < c && span_hi[i] + 1 < a) i++;
        j = i;
        while (j < c && span_lo[j] <= b + 1) j++;
        nlo = a;
        nhi = b;
        if (j > i) begin
          if (span_lo[i] < a) nlo = span_lo[i];
          if (span_hi[j-1] > b) nhi = span_hi[j-1];
        end
        if (c - (j - i) + 1 > ist_pkg::TableDepth) begin
          res.status = ist_pkg::ST_FULL;
        end else begin
          for (int k = 0; k < j - i; k++) begin
            span_lo.delete(i);
            span_hi.delete(i);
          end
          span_lo.insert(i, nlo);
          span_hi.insert(i, nhi);
        end
      end else if (ist_pkg::cmd_e'(r.command) == ist_pkg::CMD_REMOVE) begin
        i = 0;
        while (i < c && span_hi[i] < a) i++;
        j = i;
        while (j < c && span_lo[j] <= b) j++;
        np = 0;
        if (j > i) begin
          if (span_lo[i] < a) begin
            plo[np] = span_lo[i];
            phi[np] = a - 1;
            np++;
          end
          if (span_hi[j-1] > b) begin
            plo[np] = b + 1;
            phi[np] = span_hi[j-1];
            np++;
          end
        end
        if (c - (j - i) + np > ist_pkg::TableDepth) begin
          res.status = ist_pkg::ST_FULL;
        end else begin
          for (int k = 0; k < j - i; k++) begin
            span_lo.delete(i);
            span_hi.delete(i);
          end
          for (int k = np - 1; k >= 0; k--) begin
            span_lo.insert(i, plo[k]);
            span_hi.insert(i, phi[k]);
          end
        end
      end else begin
        for (i = 0; i < c; i++) begin
          if (span_lo[i] <= a && a <= span_hi[i]) begin
            if (span_hi[i] >= b) res.covered = 1'b1;
            break;
          end
        end
      end
    end
    res.interval_count = 7'(span_lo.size());
    return res;
  endfunction

  task automatic send_command(ist_pkg::cmd_e op, longint unsigned s, longint unsigned e);
    ist_pkg::req_t r;
    r.command = op;
    r.range_start = s[29:0];
    r.range_stop = e[30:0];
    while ($urandom_range(99) < send_gap_pct) @(posedge clk_i);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_rsp.insert(pending_rsp.size(), apply_command(r));
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", rsp_o);
      end else begin
        if (rsp_o !== pending_rsp[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", pending_rsp[0], rsp_o);
        end
        void'(pending_rsp.pop_front());
      end
    end
  end

  task automatic wait_drained();
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_command(ist_pkg::CMD_QUERY, 0, 10);
    send_command(ist_pkg::CMD_ADD, 5, 5);
    send_command(ist_pkg::CMD_REMOVE, 9, 3);
    send_command(ist_pkg::CMD_QUERY, 7, 7);
    send_command(ist_pkg::CMD_NONE, 3, 9);
    send_command(ist_pkg::CMD_ADD, 10, 20);
    send_command(ist_pkg::CMD_ADD, 20, 30);
    send_command(ist_pkg::CMD_ADD, 40, 50);
    send_command(ist_pkg::CMD_ADD, 31, 40);
    send_command(ist_pkg::CMD_QUERY, 10, 50);
    send_command(ist_pkg::CMD_REMOVE, 15, 25);
    send_command(ist_pkg::CMD_QUERY, 10, 15);
    send_command(ist_pkg::CMD_QUERY, 10, 16);
    send_command(ist_pkg::CMD_REMOVE, 50, 60);
    send_command(ist_pkg::CMD_ADD, 1073741823, 2147483647);
    send_command(ist_pkg::CMD_QUERY, 1073741823, 1073741824);
    send_command(ist_pkg::CMD_ADD, 0, 1);
    send_command(ist_pkg::CMD_QUERY, 1073741823, 1073741823);
    send_command(ist_pkg::CMD_REMOVE, 0, 2147483647);
    send_command(ist_pkg::CMD_ADD, 0, 1073741824);
    send_command(ist_pkg::CMD_QUERY, 0, 2147483647);
    send_command(ist_pkg::CMD_REMOVE, 0, 1073741824);
  endtask

  task automatic test_table_full();
    for (int k = 0; k < 66; k++) send_command(ist_pkg::CMD_ADD, 4 * k, 4 * k + 2);
    send_command(ist_pkg::CMD_REMOVE, 1, 2);
    send_command(ist_pkg::CMD_ADD, 4 * 64 - 1, 4 * 64);
    send_command(ist_pkg::CMD_REMOVE, 0, 2);
    send_command(ist_pkg::CMD_QUERY, 4, 6);
    wait_drained();
    send_command(ist_pkg::CMD_REMOVE, 0, 2147483647);
  endtask

  task automatic test_random(int count, int pct);
    longint unsigned s, e, base;
    int              w;
    ist_pkg::cmd_e   op;
    send_gap_pct = pct;
    for (int n = 0; n < count; n++) begin
      w = $urandom_range(99);
      op = ist_pkg::cmd_e'($urandom_range(w < 5 ? 3 : 2));
      if (w < 10) begin
        s = {$urandom} & 32'h3fff_ffff;
        e = {$urandom} & 32'h7fff_ffff;
      end else begin
        base = (w < 15) ? 64'd1073741000 : 64'd0;
        s = base + $urandom_range(600);
        e = s + $urandom_range(40);
        if ($urandom_range(19) == 0) e = s - $urandom_range(3);
      end
      if (op == ist_pkg::CMD_ADD && $urandom_range(3) == 0) e = s + $urandom_range(4);
      send_command(op, s, e);
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_random(420, 15);
    test_random(420, 85);
    test_random(420, 0);
    repeat (250) @(posedge clk_i);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
design/ist_pkg.sv
design/ist_ram.sv
design/ist_ctrl.sv
design/interval_set_table_core.sv
design/ist_checker.sv
tb/tb_interval_set_table_core.sv
